/* rtl/bole_pkg.sv */
package bole_pkg;

   localparam int CAPACITY_DEF = 16;
   localparam int VALUE_W      = 32;
   localparam int OP_W         = 2;
   localparam int COUNT_W      = 5;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND = 2'd0,
      OP_INSERT = 2'd1,
      OP_SEARCH = 2'd2,
      OP_DELETE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_APPLY,
      ST_COMPACT
   } state_type;

   // Per-cell command: at most one of load / take_lower / take_upper is set.
   typedef struct packed {
      logic capture;     // latch compare flags against the incoming key
      logic load;        // write the command operand
      logic take_lower;  // shift up: copy the neighbor below
      logic take_upper;  // shift down: copy the neighbor above, with its hole flag
   } cell_ctrl_type;

endpackage

/* rtl/bole_cell.sv */
module bole_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bole_pkg::cell_ctrl_type              ctrl,
   input  logic                                 in_use,
   input  logic signed [bole_pkg::VALUE_W-1:0]  key,
   input  logic signed [bole_pkg::VALUE_W-1:0]  new_value,
   input  logic signed [bole_pkg::VALUE_W-1:0]  lower_value,
   input  logic signed [bole_pkg::VALUE_W-1:0]  upper_value,
   input  logic                                 upper_hole,
   output logic signed [bole_pkg::VALUE_W-1:0]  entry,
   output logic                                 ge,
   output logic                                 hole
);

   logic signed [bole_pkg::VALUE_W-1:0] entry_ff, entry_in;
   logic                                ge_ff, ge_in;
   logic                                hole_ff, hole_in;

   always_comb begin
      entry_in = entry_ff;
      ge_in    = ge_ff;
      hole_in  = hole_ff;
      if (ctrl.capture) begin
         ge_in   = in_use && !(entry_ff < key);
         hole_in = in_use && (entry_ff == key);
      end
      if (ctrl.load) begin
         entry_in = new_value;
      end else if (ctrl.take_lower) begin
         entry_in = lower_value;
      end else if (ctrl.take_upper) begin
         entry_in = upper_value;
         hole_in  = upper_hole;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         ge_ff   <= 1'b0;
         hole_ff <= 1'b0;
      end else begin
         ge_ff   <= ge_in;
         hole_ff <= hole_in;
      end
   end

   assign entry = entry_ff;
   assign ge    = ge_ff;
   assign hole  = hole_ff;

endmodule

/* rtl/bounded_ordered_list_engine_core.sv */
// Channel   Ports                                              Direction
// req       req_valid req_ready req_op req_value               in
// rsp       rsp_valid rsp_ready rsp_found rsp_removed_count    out
//           rsp_dropped rsp_length
//
// Append, insert and search: the accept cycle compares the key in every
// cell, then ST_APPLY shifts/loads the chain and writes the result.
// Delete: ST_COMPACT closes one hole per cycle, then writes the result.
// Synchronous active-high reset empties the list; entry data is not cleared.
// A new item is taken only when the engine is idle; the result register lets
// the next item start while an earlier result waits for rsp_ready.
// A finishing item stalls in place while the result register is still full.
module bounded_ordered_list_engine_core #(
   parameter int CAPACITY = bole_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bole_pkg::OP_W-1:0]            req_op,
   input  logic signed [bole_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [bole_pkg::COUNT_W-1:0]         rsp_removed_count,
   output logic                                 rsp_dropped,
   output logic [bole_pkg::COUNT_W-1:0]         rsp_length
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   // control state
   bole_pkg::state_type                 state_ff, state_in;
   bole_pkg::op_type                    op_ff, op_in;
   logic signed [bole_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]                    fill_ff, fill_in;
   logic [CNT_W-1:0]                    rm_ff, rm_in;

   // result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                found_ff, found_in;
   logic                                dropped_ff, dropped_in;
   logic [CNT_W-1:0]                    rm_out_ff, rm_out_in;
   logic [CNT_W-1:0]                    len_out_ff, len_out_in;

   // chain taps
   logic signed [bole_pkg::VALUE_W-1:0] entry_vec [CAPACITY];
   logic [CAPACITY-1:0]                 ge_vec, hole_vec, in_use_vec, tail_hot;
   logic [CAPACITY-1:0]                 ins_vec, first_hot, above_mask;
   logic [CAPACITY-1:0]                 hole_first, shift_mask;
   bole_pkg::cell_ctrl_type             cell_ctrl [CAPACITY];

   logic accept, rsp_free, full, emit, do_insert, do_shift;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign full     = (fill_ff == CNT_W'(CAPACITY));

   // Insertion point: first cell whose entry >= key, else the tail slot.
   assign ins_vec    = ((op_ff == bole_pkg::OP_INSERT) ? ge_vec : '0) | tail_hot;
   assign first_hot  = ins_vec & (~ins_vec + CAPACITY'(1));
   assign above_mask = ~((first_hot - CAPACITY'(1)) | first_hot);

   // Compaction: every cell at or above the lowest hole pulls from above.
   assign hole_first = hole_vec & (~hole_vec + CAPACITY'(1));
   assign shift_mask = (hole_vec != '0) ? ~(hole_first - CAPACITY'(1)) : '0;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic signed [bole_pkg::VALUE_W-1:0] lower_v, upper_v;
         logic                                upper_h;

         assign in_use_vec[gi] = (fill_ff > CNT_W'(gi));
         assign tail_hot[gi]   = (fill_ff == CNT_W'(gi));

         if (gi == 0) begin : g_bottom
            assign lower_v = entry_vec[gi];
         end else begin : g_lower
            assign lower_v = entry_vec[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_top
            assign upper_v = entry_vec[gi];
            assign upper_h = 1'b0;
         end else begin : g_upper
            assign upper_v = entry_vec[gi+1];
            assign upper_h = hole_vec[gi+1];
         end

         always_comb begin
            cell_ctrl[gi].capture    = accept;
            cell_ctrl[gi].load       = do_insert && first_hot[gi];
            cell_ctrl[gi].take_lower = do_insert && above_mask[gi];
            cell_ctrl[gi].take_upper = do_shift && shift_mask[gi];
         end

         bole_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (cell_ctrl[gi]),
            .in_use      (in_use_vec[gi]),
            .key         (req_value),
            .new_value   (value_ff),
            .lower_value (lower_v),
            .upper_value (upper_v),
            .upper_hole  (upper_h),
            .entry       (entry_vec[gi]),
            .ge          (ge_vec[gi]),
            .hole        (hole_vec[gi])
         );
      end
   endgenerate

   // next state and outputs
   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      value_in   = value_ff;
      fill_in    = fill_ff;
      rm_in      = rm_ff;
      req_ready  = (state_ff == bole_pkg::ST_IDLE);
      emit       = 1'b0;
      do_insert  = 1'b0;
      do_shift   = 1'b0;
      found_in   = found_ff;
      dropped_in = dropped_ff;
      rm_out_in  = rm_out_ff;
      len_out_in = len_out_ff;

      case (state_ff)
         bole_pkg::ST_IDLE: begin
            if (accept) begin
               op_in    = bole_pkg::op_type'(req_op);
               value_in = req_value;
               rm_in    = '0;
               state_in = (bole_pkg::op_type'(req_op) == bole_pkg::OP_DELETE) ?
                          bole_pkg::ST_COMPACT : bole_pkg::ST_APPLY;
            end
         end
         bole_pkg::ST_APPLY: begin
            if (rsp_free) begin
               emit       = 1'b1;
               state_in   = bole_pkg::ST_IDLE;
               rm_out_in  = '0;
               found_in   = 1'b0;
               dropped_in = 1'b0;
               len_out_in = fill_ff;
               if (op_ff == bole_pkg::OP_SEARCH) begin
                  found_in = (hole_vec != '0);
               end else if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  do_insert  = 1'b1;
                  fill_in    = fill_ff + CNT_W'(1);
                  len_out_in = fill_ff + CNT_W'(1);
               end
            end
         end
         bole_pkg::ST_COMPACT: begin
            if (hole_vec != '0) begin
               do_shift = 1'b1;
               rm_in    = rm_ff + CNT_W'(1);
               fill_in  = fill_ff - CNT_W'(1);
            end else if (rsp_free) begin
               emit       = 1'b1;
               state_in   = bole_pkg::ST_IDLE;
               found_in   = (rm_ff != '0);
               dropped_in = 1'b0;
               rm_out_in  = rm_ff;
               len_out_in = fill_ff;
            end
         end
         default: begin
            state_in = bole_pkg::ST_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      value_ff   <= value_in;
      found_ff   <= found_in;
      dropped_ff <= dropped_in;
      rm_out_ff  <= rm_out_in;
      len_out_ff <= len_out_in;
      if (reset) begin
         state_ff     <= bole_pkg::ST_IDLE;
         fill_ff      <= '0;
         rm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rm_ff        <= rm_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // counts are masked to the 5-bit result fields
   logic [CNT_W+bole_pkg::COUNT_W-1:0] rm_ext, len_ext;
   assign rm_ext  = {{bole_pkg::COUNT_W{1'b0}}, rm_out_ff};
   assign len_ext = {{bole_pkg::COUNT_W{1'b0}}, len_out_ff};

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_dropped       = dropped_ff;
   assign rsp_removed_count = rm_ext[bole_pkg::COUNT_W-1:0];
   assign rsp_length        = len_ext[bole_pkg::COUNT_W-1:0];

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(CAPACITY))
      else $error("fill count above capacity");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff != bole_pkg::ST_IDLE))
      else $error("result raised without an item in flight");

   a_one_hole: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hole_first) && $onehot0(first_hot))
      else $error("more than one insertion or hole point");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bole_pkg::ST_COMPACT && hole_vec != '0) |-> fill_ff != '0)
      else $error("compaction with empty list");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bole_pkg::ST_APPLY && rsp_free && full) |=> $stable(fill_ff))
      else $error("full list changed length");

endmodule

/* test/bounded_ordered_list_engine_core_test.sv */
`timescale 1ns / 1ps

module bounded_ordered_list_engine_core_test;

   localparam int LIST_DEPTH  = bole_pkg::CAPACITY_DEF;
   localparam int HOLD_CYCLES = 300;
   localparam int DRAIN_WAIT  = 30;     // extra wait after drain; covers a delete of a full list
   localparam int REPORT_MAX  = 10;

   typedef struct {
      bole_pkg::op_type                    op;
      logic signed [bole_pkg::VALUE_W-1:0] value;
   } list_cmd_type;

   typedef struct packed {
      logic                         found;
      logic [bole_pkg::COUNT_W-1:0] removed_count;
      logic                         dropped;
      logic [bole_pkg::COUNT_W-1:0] length;
   } list_result_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_ready;
   logic [bole_pkg::OP_W-1:0]           req_op = bole_pkg::OP_APPEND;
   logic signed [bole_pkg::VALUE_W-1:0] req_value = '0;
   logic                                rsp_valid;
   logic                                rsp_ready = 1'b0;
   logic                                rsp_found;
   logic [bole_pkg::COUNT_W-1:0]        rsp_removed_count;
   logic                                rsp_dropped;
   logic [bole_pkg::COUNT_W-1:0]        rsp_length;

   // stimulus side
   list_cmd_type cmd_queue[$];
   int           queued_total = 0;
   int           accepted_total = 0;
   int           gap_pct = 0;
   int           stall_pct = 0;
   int           hold_req = 0;
   int           hold_seen = 0;
   int           hold_left = 0;
   logic         req_took = 1'b0;

   // shadow copy of the list and the results it predicts
   logic signed [bole_pkg::VALUE_W-1:0] shadow_list[LIST_DEPTH];
   int                                  shadow_len = 0;
   list_result_type                     result_queue[$];
   int                                  error_count = 0;

   bounded_ordered_list_engine_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_removed_count (rsp_removed_count),
      .rsp_dropped       (rsp_dropped),
      .rsp_length        (rsp_length)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Runs one command against the shadow list and returns its result.
   function automatic list_result_type apply_list_command(
         bole_pkg::op_type op, logic signed [bole_pkg::VALUE_W-1:0] value);
      list_result_type res;
      int              pos;
      int              keep;
      res = '0;
      case (op)
         bole_pkg::OP_APPEND, bole_pkg::OP_INSERT: begin
            if (shadow_len >= LIST_DEPTH) begin
               res.dropped = 1'b1;
            end else begin
               pos = shadow_len;
               if (op == bole_pkg::OP_INSERT) begin
                  // scan from the tail down so the lowest matching slot wins
                  for (int i = shadow_len - 1; i >= 0; i--)
                     if (shadow_list[i] >= value) pos = i;
                  for (int i = shadow_len; i > pos; i--)
                     shadow_list[i] = shadow_list[i-1];
               end
               shadow_list[pos] = value;
               shadow_len++;
            end
         end
         bole_pkg::OP_SEARCH: begin
            for (int i = 0; i < shadow_len; i++)
               if (shadow_list[i] == value) res.found = 1'b1;
         end
         bole_pkg::OP_DELETE: begin
            keep = 0;
            for (int i = 0; i < shadow_len; i++) begin
               if (shadow_list[i] != value) begin
                  shadow_list[keep] = shadow_list[i];
                  keep++;
               end
            end
            res.removed_count = bole_pkg::COUNT_W'(shadow_len - keep);
            res.found         = (keep != shadow_len);
            shadow_len        = keep;
         end
         default: begin
            res = '0;
         end
      endcase
      res.length = bole_pkg::COUNT_W'(shadow_len);
      return res;
   endfunction

   // Monitor: predicts on every accepted command, checks every accepted result.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            result_queue.push_back(
               apply_list_command(bole_pkg::op_type'(req_op), req_value));
            accepted_total++;
         end
         if (rsp_valid && rsp_ready) begin
            if (result_queue.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("ERROR: unexpected result found=%0b removed=%0d dropped=%0b len=%0d",
                           rsp_found, rsp_removed_count, rsp_dropped, rsp_length);
            end else begin
               want = result_queue.pop_front();
               if (rsp_found !== want.found || rsp_removed_count !== want.removed_count ||
                   rsp_dropped !== want.dropped || rsp_length !== want.length) begin
                  error_count++;
                  if (error_count <= REPORT_MAX)
                     $display({"ERROR: result mismatch exp found=%0b removed=%0d dropped=%0b ",
                               "len=%0d, got found=%0b removed=%0d dropped=%0b len=%0d"},
                              want.found, want.removed_count, want.dropped, want.length,
                              rsp_found, rsp_removed_count, rsp_dropped, rsp_length);
               end
            end
         end
      end
      req_took <= !reset && req_valid && req_ready;
   end

   // Driver: holds an item until it is taken, then may idle before the next one.
   always @(negedge clock) begin
      list_cmd_type cmd;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
            cmd = cmd_queue.pop_front();
            req_valid <= 1'b1;
            req_op    <= cmd.op;
            req_value <= cmd.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Only called right after a rising edge, so never races the driver.
   task automatic queue_cmd(bole_pkg::op_type op, logic signed [bole_pkg::VALUE_W-1:0] value);
      list_cmd_type cmd;
      cmd.op    = op;
      cmd.value = value;
      cmd_queue.push_back(cmd);
      queued_total++;
   endtask

   // Mostly a small pool so searches and deletes hit; some extremes, some noise.
   function automatic logic signed [bole_pkg::VALUE_W-1:0] pick_value();
      int sel;
      int small_val;
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         small_val = $urandom_range(0, 7);
         return small_val - 4;
      end
      if (sel < 8) begin
         case ($urandom_range(0, 3))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            2:       return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic queue_random_items(int count);
      int                                  pushed;
      int                                  burst;
      logic signed [bole_pkg::VALUE_W-1:0] v;
      pushed = 0;
      while (pushed < count) begin
         case ($urandom_range(0, 9))
            6, 7: begin
               // fill run of one value, often past full, then wipe it out
               v = pick_value();
               burst = $urandom_range(4, 18);
               for (int i = 0; i < burst; i++)
                  queue_cmd(($urandom_range(0, 1) != 0) ? bole_pkg::OP_INSERT
                                                        : bole_pkg::OP_APPEND, v);
               queue_cmd(bole_pkg::OP_DELETE, v);
               pushed += burst + 1;
            end
            8: begin
               // noise: full-range lookups that almost never hit
               queue_cmd(($urandom_range(0, 1) != 0) ? bole_pkg::OP_SEARCH
                                                     : bole_pkg::OP_DELETE, $urandom);
               pushed++;
            end
            9: begin
               v = pick_value();
               queue_cmd(bole_pkg::OP_SEARCH, v);
               queue_cmd(bole_pkg::OP_DELETE, v);
               pushed += 2;
            end
            default: begin
               queue_cmd(bole_pkg::op_type'($urandom_range(bole_pkg::OP_APPEND,
                                                           bole_pkg::OP_DELETE)),
                         pick_value());
               pushed++;
            end
         endcase
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (accepted_total != queued_total || result_queue.size() != 0);
   endtask

   task automatic run_phase(int gap, int stall, int count);
      wait_drained();
      @(posedge clock);
      gap_pct   = gap;
      stall_pct = stall;
      queue_random_items(count);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, unsorted contents, full list
      @(posedge clock);
      queue_cmd(bole_pkg::OP_SEARCH, 32'sd0);
      queue_cmd(bole_pkg::OP_DELETE, 32'sd5);
      queue_cmd(bole_pkg::OP_INSERT, 32'sh7fff_ffff);
      queue_cmd(bole_pkg::OP_INSERT, 32'sh8000_0000);
      queue_cmd(bole_pkg::OP_INSERT, -32'sd1);
      queue_cmd(bole_pkg::OP_INSERT, 32'sd0);
      queue_cmd(bole_pkg::OP_APPEND, -32'sd5);       // breaks the ordering on purpose
      queue_cmd(bole_pkg::OP_INSERT, -32'sd3);       // still lands before first >= value
      queue_cmd(bole_pkg::OP_SEARCH, 32'sh8000_0000);
      queue_cmd(bole_pkg::OP_SEARCH, 32'sh7fff_ffff);
      queue_cmd(bole_pkg::OP_SEARCH, 32'sd7);
      queue_cmd(bole_pkg::OP_DELETE, 32'sh8000_0000);
      queue_cmd(bole_pkg::OP_DELETE, 32'sh7fff_ffff);
      for (int i = 0; i < LIST_DEPTH - 4; i++)
         queue_cmd(bole_pkg::OP_APPEND, 32'sd42);
      queue_cmd(bole_pkg::OP_APPEND, 32'sd1);        // full: refused
      queue_cmd(bole_pkg::OP_INSERT, 32'sd1);        // full: refused
      queue_cmd(bole_pkg::OP_DELETE, 32'sd42);

      run_phase(0,  0,  75);
      run_phase(74, 0,  75);
      run_phase(0,  74, 75);
      run_phase(30, 30, 75);

      // receiver holds off while the sender keeps pushing, so the input backs up
      wait_drained();
      @(posedge clock);
      gap_pct   = 0;
      stall_pct = 0;
      hold_req++;
      queue_random_items(30);

      run_phase(30, 30, 75);

      wait_drained();
      repeat (DRAIN_WAIT) @(negedge clock);
      error_count += result_queue.size();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
